>>> rtl/fpsa_pkg.sv
// Package for the fixed pool slot allocator.
// Holds pool sizing constants, request codes and result status codes.
// No dependencies.
`timescale 1ns / 1ps

package fpsa_pkg;

	// Pool geometry.
	localparam int SLOTS   = 64;
	localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W   = $clog2(SLOTS + 1);

	// Fixed field widths of the channels and the register.
	localparam int POOL_W  = 7;
	localparam int COORD_W = 32;
	localparam int SLOT_W  = 8;
	localparam int GRANT_W = 6;
	localparam int FREE_W  = 7;

	// Request codes.
	typedef enum logic {
		REQ_ACQUIRE = 1'b0,
		REQ_RELEASE = 1'b1
	} req_type_t;

	// Result status codes.
	typedef enum logic [2:0] {
		STS_ACQUIRED  = 3'd0,
		STS_EMPTY     = 3'd1,
		STS_RELEASED  = 3'd2,
		STS_NULL      = 3'd3,
		STS_RANGE     = 3'd4,
		STS_ALREADY   = 3'd5
	} status_t;

endpackage

>>> rtl/fpsa_if.sv
// Valid/ready channel interfaces for the slot allocator requests and results.
// Depends on fpsa_pkg for field widths and codes.
`timescale 1ns / 1ps

interface fpsa_req_if;
	import fpsa_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 req_type;
	logic [COORD_W-1:0]   spawn_x;
	logic [COORD_W-1:0]   spawn_y;
	logic [SLOT_W-1:0]    slot_index;
	logic                 handle_null;

	modport source (output valid, req_type, spawn_x, spawn_y, slot_index, handle_null,
		input ready);
	modport sink (input valid, req_type, spawn_x, spawn_y, slot_index, handle_null,
		output ready);
endinterface

interface fpsa_rsp_if;
	import fpsa_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [2:0]           status;
	logic [GRANT_W-1:0]   granted_slot;
	logic [FREE_W-1:0]    free_count;

	modport source (output valid, status, granted_slot, free_count, input ready);
	modport sink (input valid, status, granted_slot, free_count, output ready);
endinterface

>>> rtl/fixed_pool_slot_allocator.sv
// Fixed pool slot allocator: LIFO free-index stack in a synchronous memory.
// Flow: the request is captured at acceptance, and ST_EXEC registers the result.
// Issue: no new request is taken until ST_EXEC is over and the result register is free;
// the stack memory is read at acceptance and the pop or push writes back in ST_EXEC, before the next read.
// Reset: asynchronous; the pool is full at 64 slots, no slot is in use, and the
// stack needs no clearing pass because per-entry valid bits supply its fill.
`timescale 1ns / 1ps

module fixed_pool_slot_allocator
	import fpsa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [POOL_W-1:0] cfg_wdata,
	fpsa_req_if.sink          req,
	fpsa_rsp_if.source        rsp
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t              state_q;
	logic [POOL_W-1:0]   pool_size_q;
	logic [CNT_W-1:0]    depth_q;
	logic [SLOTS-1:0]    stack_vld_q;
	logic [SLOTS-1:0]    busy_q;
	logic                rsp_vld_q;
	logic [2:0]          rsp_status_q;
	logic [GRANT_W-1:0]  rsp_grant_q;
	logic [FREE_W-1:0]   rsp_free_q;

	// Captured request and stack read data.
	logic                req_type_s1;
	logic [COORD_W-1:0]  spawn_x_s1;
	logic [COORD_W-1:0]  spawn_y_s1;
	logic [SLOT_W-1:0]   slot_index_s1;
	logic                handle_null_s1;
	logic [IDX_W-1:0]    stack_rd_s1;

	// Memories: the free-index stack and the per-slot coordinate words.
	logic [IDX_W-1:0]         stack_mem [SLOTS];
	logic [2*COORD_W-1:0]     coord_mem [SLOTS];

	logic                req_acc;
	logic                exec;
	logic [CNT_W-1:0]    eff_size;
	logic [CNT_W-1:0]    cfg_eff;
	logic [IDX_W-1:0]    top_addr;
	logic [IDX_W-1:0]    push_addr;
	logic [IDX_W-1:0]    rel_slot;
	logic [IDX_W-1:0]    pop_slot;
	logic                is_acq;
	logic                pop_en;
	logic                range_bad;
	logic                rel_ok;
	logic                push_en;
	logic [CNT_W-1:0]    depth_nxt;
	status_t             status_nxt;

	// Effective pool size saturates at the number of physical slots.
	assign eff_size = (32'(pool_size_q) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(pool_size_q);
	assign cfg_eff  = (32'(cfg_wdata) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(cfg_wdata);

	// Handshake: take a request only when idle and the result register is free.
	assign req.ready = (state_q == ST_IDLE) && (!rsp_vld_q || rsp.ready);
	assign req_acc   = req.valid && req.ready;
	assign exec      = (state_q == ST_EXEC);

	assign rsp.valid        = rsp_vld_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.granted_slot = rsp_grant_q;
	assign rsp.free_count   = rsp_free_q;

	// Stack addresses: top entry for a pop, next free entry for a push.
	assign top_addr  = IDX_W'(depth_q - CNT_W'(1));
	assign push_addr = IDX_W'(depth_q);
	assign rel_slot  = IDX_W'(slot_index_s1);

	// An entry never written since the last refill holds its initial index.
	assign pop_slot = stack_vld_q[top_addr] ? stack_rd_s1 : IDX_W'(eff_size - depth_q);

	// Decode the captured request against the state and the stack entry read at acceptance.
	always_comb begin
		is_acq     = (req_type_s1 == REQ_ACQUIRE);
		pop_en     = 1'b0;
		push_en    = 1'b0;
		range_bad  = (32'(slot_index_s1) >= 32'(eff_size));
		rel_ok     = 1'b0;
		depth_nxt  = depth_q;
		status_nxt = STS_ACQUIRED;
		if (is_acq) begin
			if (depth_q == '0) begin
				status_nxt = STS_EMPTY;
			end else begin
				pop_en    = exec;
				depth_nxt = depth_q - CNT_W'(1);
			end
		end else if (handle_null_s1) begin
			status_nxt = STS_NULL;
		end else if (range_bad) begin
			status_nxt = STS_RANGE;
		end else if (!busy_q[rel_slot]) begin
			status_nxt = STS_ALREADY;
		end else begin
			status_nxt = STS_RELEASED;
			rel_ok     = exec;
			if (32'(depth_q) < SLOTS) begin
				push_en   = exec;
				depth_nxt = depth_q + CNT_W'(1);
			end
		end
	end

	// Capture the request payload at acceptance.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_type_s1    <= req.req_type;
			spawn_x_s1     <= req.spawn_x;
			spawn_y_s1     <= req.spawn_y;
			slot_index_s1  <= req.slot_index;
			handle_null_s1 <= req.handle_null;
		end
	end

	// Free-index stack memory: read at acceptance, written back on a push.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			stack_rd_s1 <= stack_mem[top_addr];
		end
		if (push_en) begin
			stack_mem[push_addr] <= rel_slot;
		end
	end

	// Coordinate store: written on every granted acquire.
	always_ff @(posedge clk) begin
		if (pop_en) begin
			coord_mem[pop_slot] <= {spawn_y_s1, spawn_x_s1};
		end
	end

	// Control state, pool bookkeeping and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pool_size_q  <= POOL_W'(64);
			depth_q      <= (SLOTS > 64) ? CNT_W'(64) : CNT_W'(SLOTS);
			stack_vld_q  <= '0;
			busy_q       <= '0;
			rsp_vld_q    <= 1'b0;
			rsp_status_q <= STS_ACQUIRED;
			rsp_grant_q  <= '0;
			rsp_free_q   <= '0;
		end else begin
			if (rsp_vld_q && rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_we) begin
						pool_size_q <= cfg_wdata;
						depth_q     <= cfg_eff;
						stack_vld_q <= '0;
						busy_q      <= '0;
					end else if (req_acc) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q      <= ST_IDLE;
					depth_q      <= depth_nxt;
					rsp_vld_q    <= 1'b1;
					rsp_status_q <= status_nxt;
					rsp_grant_q  <= pop_en ? GRANT_W'(pop_slot) : '0;
					rsp_free_q   <= FREE_W'(depth_nxt);
					if (pop_en) begin
						busy_q[pop_slot] <= 1'b1;
					end
					if (rel_ok) begin
						busy_q[rel_slot] <= 1'b0;
					end
					if (push_en) begin
						stack_vld_q[push_addr] <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	// The free stack never holds more indices than the pool has slots.
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= eff_size)
		else $error("free stack deeper than the pool");

	// A popped slot must not already be in use.
	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop_en |-> !busy_q[pop_slot])
		else $error("granted a slot that is already in use");

	// A new result appears only at the end of the execute cycle.
	a_rsp_timing: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_vld_q) |-> $past(state_q == ST_EXEC))
		else $error("result raised outside the execute cycle");

	// Only a successful acquire carries a nonzero granted slot.
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_vld_q && rsp_status_q != STS_ACQUIRED) |-> (rsp_grant_q == '0))
		else $error("granted slot set on a result that grants nothing");
`endif

endmodule
